[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the synchronous reset is low.
`define ASSERT_CLK_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define ASSERT_CLK(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

[hw/rtl/scpo_pkg.sv]
// ----------------------------------------------------------------------------
// scpo_pkg
// Shared types and constants of the convex polygon overlap core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package scpo_pkg;

    localparam int DEF_MAX_VERTICES = 16;
    localparam int DEF_COORD_BITS   = 16;

    localparam int VERTEX_W   = 16;
    localparam int IN_DATA_W  = 2 * VERTEX_W;
    localparam int AXIS_OUT_W = 5;
    localparam int STATUS_W   = 2;
    localparam int OUT_DATA_W = 8;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_OVERFLOW = 2'd1,
        STATUS_EMPTY    = 2'd2
    } t_status;

    typedef struct packed {
        logic load_axis;
        logic mul_x;
        logic mul_y;
        logic cmp;
        logic cmp_first;
        logic save_a;
    } t_mac_ctrl;

endpackage

[hw/rtl/scpo_ram.sv]
// ----------------------------------------------------------------------------
// scpo_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scpo_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/scpo_mac.sv]
// ----------------------------------------------------------------------------
// scpo_mac
// Shared multiply-accumulate unit with axis setup and projection min/max.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scpo_mac #(
    parameter int COORD_BITS = scpo_pkg::DEF_COORD_BITS
) (
    input  logic                             i_clk,
    input  scpo_pkg::t_mac_ctrl              i_ctrl,
    input  logic [scpo_pkg::IN_DATA_W-1:0]   i_vi,
    input  logic [scpo_pkg::IN_DATA_W-1:0]   i_vrd,
    output logic                             o_separates
);

    import scpo_pkg::*;

    localparam int CW  = (COORD_BITS < VERTEX_W) ? COORD_BITS : VERTEX_W;
    localparam int AXW = CW + 1;
    localparam int PW  = 2 * CW + 1;
    localparam int ACW = 2 * CW + 2;

    logic signed [CW-1:0]  w_xi;
    logic signed [CW-1:0]  w_yi;
    logic signed [CW-1:0]  w_x;
    logic signed [CW-1:0]  w_y;
    logic signed [CW-1:0]  w_op_a;
    logic signed [AXW-1:0] w_op_b;
    logic signed [PW-1:0]  w_prod;

    logic signed [AXW-1:0] r_ax;
    logic signed [AXW-1:0] r_ay;
    logic signed [ACW-1:0] r_acc;
    logic signed [ACW-1:0] r_pmin;
    logic signed [ACW-1:0] r_pmax;
    logic signed [ACW-1:0] r_amin;
    logic signed [ACW-1:0] r_amax;

    assign w_xi = i_vi[CW-1:0];
    assign w_yi = i_vi[VERTEX_W+CW-1:VERTEX_W];
    assign w_x  = i_vrd[CW-1:0];
    assign w_y  = i_vrd[VERTEX_W+CW-1:VERTEX_W];

    assign w_op_a = i_ctrl.mul_y ? w_y : w_x;
    assign w_op_b = i_ctrl.mul_y ? r_ay : r_ax;
    assign w_prod = PW'(w_op_a) * PW'(w_op_b);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_axis) begin
            r_ax <= AXW'(w_y) - AXW'(w_yi);
            r_ay <= AXW'(w_xi) - AXW'(w_x);
        end
        if (i_ctrl.mul_x) begin
            r_acc <= ACW'(w_prod);
        end else if (i_ctrl.mul_y) begin
            r_acc <= r_acc + ACW'(w_prod);
        end
        if (i_ctrl.cmp) begin
            if (i_ctrl.cmp_first || r_acc < r_pmin) begin
                r_pmin <= r_acc;
            end
            if (i_ctrl.cmp_first || r_acc > r_pmax) begin
                r_pmax <= r_acc;
            end
        end
        if (i_ctrl.save_a) begin
            r_amin <= r_pmin;
            r_amax <= r_pmax;
        end
    end

    assign o_separates = (r_pmin > r_amax) || (r_pmax < r_amin);

endmodule

[hw/rtl/sat_convex_polygon_overlap_core.sv]
// ----------------------------------------------------------------------------
// sat_convex_polygon_overlap_core
// Separating-axis overlap test of two convex polygons in Q12.4 coordinates.
// ----------------------------------------------------------------------------
// Vertices enter on the s_axis channel, one per transfer: tdata holds x in
// bits 15:0 and y in bits 31:16, tuser selects polygon B, and tlast marks the
// final vertex and starts the test. Loading takes one vertex per cycle.
// The transfer with tlast yields exactly one result on the m_axis channel:
// collide in bit 0, the first separating axis in bits 5:1, status in 7:6.
// Overflow and empty polygons answer in the cycle after tlast. Otherwise
// the test walks every edge of A and then of B through one shared multiplier,
// two products per vertex projection, and stops early on a separating axis.
// s_axis_tready stays low from tlast until the result transfer is done;
// a stalled receiver simply holds the result. Reset clears the vertex counts
// and the overflow flag; the vertex memories need no clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sat_convex_polygon_overlap_core #(
    parameter int MAX_VERTICES = scpo_pkg::DEF_MAX_VERTICES,
    parameter int COORD_BITS   = scpo_pkg::DEF_COORD_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // vertex_x [15:0], vertex_y [31:16]
    input  logic [scpo_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // second_polygon [0]
    input  logic                            s_axis_tuser,
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // collide [0], separating_axis [5:1], status [7:6]
    output logic [scpo_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    import scpo_pkg::*;

    localparam int AW    = $clog2(MAX_VERTICES);
    localparam int CNW   = $clog2(MAX_VERTICES + 1);
    localparam int AXL   = $clog2(2 * MAX_VERTICES);
    localparam int AXIDW = (AXL > AXIS_OUT_W) ? AXL : AXIS_OUT_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EDGE_I,
        S_EDGE_J,
        S_AXIS,
        S_MX,
        S_MY,
        S_CMP,
        S_NEXTPOLY,
        S_CHECK,
        S_OUT
    } t_state;

    t_state                r_state;
    logic [CNW-1:0]        r_count_a;
    logic [CNW-1:0]        r_count_b;
    logic                  r_ovf;
    logic                  r_edge_b;
    logic                  r_proj_b;
    logic [AW-1:0]         r_ei;
    logic [AW-1:0]         r_p;
    logic [AXIDW-1:0]      r_axis;
    logic                  r_rsel;
    logic [IN_DATA_W-1:0]  r_vi;
    logic                  r_collide;
    logic [AXIS_OUT_W-1:0] r_axis_out;
    t_status               r_status;

    logic                  w_fire;
    logic                  w_wr_a;
    logic                  w_wr_b;
    logic [CNW-1:0]        n_count_a;
    logic [CNW-1:0]        n_count_b;
    logic                  n_ovf;
    logic [CNW-1:0]        w_n_edge;
    logic [CNW-1:0]        w_n_proj;
    logic                  w_ei_more;
    logic                  w_p_more;
    logic [AW-1:0]         w_ei_next;
    logic [AW-1:0]         w_p_next;
    logic [AW-1:0]         w_j;
    logic                  w_re;
    logic                  w_re_b;
    logic [AW-1:0]         w_raddr;
    logic [IN_DATA_W-1:0]  w_rdata_a;
    logic [IN_DATA_W-1:0]  w_rdata_b;
    logic [IN_DATA_W-1:0]  w_rdata;
    t_mac_ctrl             w_ctrl;
    logic                  w_separates;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {r_status, r_axis_out, r_collide};

    assign w_fire    = s_axis_tvalid && s_axis_tready;
    assign w_wr_a    = w_fire && !s_axis_tuser && (r_count_a < CNW'(MAX_VERTICES));
    assign w_wr_b    = w_fire && s_axis_tuser && (r_count_b < CNW'(MAX_VERTICES));
    assign n_count_a = r_count_a + CNW'(w_wr_a);
    assign n_count_b = r_count_b + CNW'(w_wr_b);
    assign n_ovf     = r_ovf || (w_fire && !w_wr_a && !w_wr_b);

    assign w_n_edge  = r_edge_b ? r_count_b : r_count_a;
    assign w_n_proj  = r_proj_b ? r_count_b : r_count_a;
    assign w_ei_more = (CNW'(r_ei) + CNW'(1)) < w_n_edge;
    assign w_p_more  = (CNW'(r_p) + CNW'(1)) < w_n_proj;
    assign w_ei_next = r_ei + AW'(1);
    assign w_p_next  = r_p + AW'(1);
    assign w_j       = w_ei_more ? w_ei_next : '0;

    always_comb begin
        w_re    = 1'b0;
        w_re_b  = 1'b0;
        w_raddr = '0;
        w_ctrl  = '0;
        unique case (r_state)
            S_EDGE_I: begin
                w_re    = 1'b1;
                w_re_b  = r_edge_b;
                w_raddr = r_ei;
            end
            S_EDGE_J: begin
                w_re    = 1'b1;
                w_re_b  = r_edge_b;
                w_raddr = w_j;
            end
            S_AXIS: begin
                w_re             = 1'b1;
                w_ctrl.load_axis = 1'b1;
            end
            S_MX: begin
                w_ctrl.mul_x = 1'b1;
            end
            S_MY: begin
                w_ctrl.mul_y = 1'b1;
                w_re         = w_p_more;
                w_re_b       = r_proj_b;
                w_raddr      = w_p_next;
            end
            S_CMP: begin
                w_ctrl.cmp       = 1'b1;
                w_ctrl.cmp_first = (r_p == '0);
            end
            S_NEXTPOLY: begin
                w_re          = 1'b1;
                w_re_b        = 1'b1;
                w_ctrl.save_a = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign w_rdata = r_rsel ? w_rdata_b : w_rdata_a;

    scpo_ram #(
        .WIDTH (IN_DATA_W),
        .DEPTH (MAX_VERTICES)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (w_wr_a),
        .i_waddr (r_count_a[AW-1:0]),
        .i_wdata (s_axis_tdata),
        .i_re    (w_re && !w_re_b),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_a)
    );

    scpo_ram #(
        .WIDTH (IN_DATA_W),
        .DEPTH (MAX_VERTICES)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_wr_b),
        .i_waddr (r_count_b[AW-1:0]),
        .i_wdata (s_axis_tdata),
        .i_re    (w_re && w_re_b),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_b)
    );

    scpo_mac #(
        .COORD_BITS (COORD_BITS)
    ) u_mac (
        .i_clk       (i_clk),
        .i_ctrl      (w_ctrl),
        .i_vi        (r_vi),
        .i_vrd       (w_rdata),
        .o_separates (w_separates)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count_a <= '0;
            r_count_b <= '0;
            r_ovf     <= 1'b0;
        end else begin
            if (w_re) begin
                r_rsel <= w_re_b;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_fire) begin
                        r_count_a <= n_count_a;
                        r_count_b <= n_count_b;
                        r_ovf     <= n_ovf;
                        if (s_axis_tlast) begin
                            r_collide  <= 1'b0;
                            r_axis_out <= '0;
                            r_edge_b   <= 1'b0;
                            r_ei       <= '0;
                            r_axis     <= '0;
                            if (n_ovf) begin
                                r_status <= STATUS_OVERFLOW;
                                r_state  <= S_OUT;
                            end else if (n_count_a == '0 || n_count_b == '0) begin
                                r_status <= STATUS_EMPTY;
                                r_state  <= S_OUT;
                            end else begin
                                r_status <= STATUS_OK;
                                r_state  <= S_EDGE_I;
                            end
                        end
                    end
                end
                S_EDGE_I: begin
                    r_state <= S_EDGE_J;
                end
                S_EDGE_J: begin
                    r_vi    <= w_rdata;
                    r_state <= S_AXIS;
                end
                S_AXIS: begin
                    r_proj_b <= 1'b0;
                    r_p      <= '0;
                    r_state  <= S_MX;
                end
                S_MX: begin
                    r_state <= S_MY;
                end
                S_MY: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (w_p_more) begin
                        r_p     <= w_p_next;
                        r_state <= S_MX;
                    end else if (!r_proj_b) begin
                        r_state <= S_NEXTPOLY;
                    end else begin
                        r_state <= S_CHECK;
                    end
                end
                S_NEXTPOLY: begin
                    r_proj_b <= 1'b1;
                    r_p      <= '0;
                    r_state  <= S_MX;
                end
                S_CHECK: begin
                    if (w_separates) begin
                        r_collide  <= 1'b0;
                        r_axis_out <= r_axis[AXIS_OUT_W-1:0];
                        r_state    <= S_OUT;
                    end else if (w_ei_more) begin
                        r_ei    <= w_ei_next;
                        r_axis  <= r_axis + AXIDW'(1);
                        r_state <= S_EDGE_I;
                    end else if (!r_edge_b) begin
                        r_edge_b <= 1'b1;
                        r_ei     <= '0;
                        r_axis   <= r_axis + AXIDW'(1);
                        r_state  <= S_EDGE_I;
                    end else begin
                        r_collide  <= 1'b1;
                        r_axis_out <= '0;
                        r_state    <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_count_a <= '0;
                        r_count_b <= '0;
                        r_ovf     <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[hw/rtl/scpo_checker.sv]
// ----------------------------------------------------------------------------
// scpo_checker
// Port-level assertions for the convex polygon overlap core, bound to it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scpo_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [scpo_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input logic                            s_axis_tuser,
    input logic                            s_axis_tlast,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [scpo_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    import scpo_pkg::*;

    logic w_in_xfer;
    logic w_out_stall;
    logic w_out_err;

    assign w_in_xfer   = s_axis_tvalid && s_axis_tready;
    assign w_out_stall = m_axis_tvalid && !m_axis_tready;
    assign w_out_err   = m_axis_tvalid && (m_axis_tdata[7:6] != STATUS_OK);

    `ASSERT_CLK_RST(a_no_overlap, i_clk, i_rst_n, !(s_axis_tready && m_axis_tvalid))
    `ASSERT_CLK_RST(a_load_ready, i_clk, i_rst_n, (w_in_xfer && !s_axis_tlast) |=> s_axis_tready)
    `ASSERT_CLK_RST(a_last_busy, i_clk, i_rst_n, (w_in_xfer && s_axis_tlast) |=> !s_axis_tready)
    `ASSERT_CLK_RST(a_err_clean, i_clk, i_rst_n, w_out_err |-> (m_axis_tdata[5:0] == 6'd0))
    `ASSERT_CLK_RST(a_out_hold, i_clk, i_rst_n, w_out_stall |=> $stable(m_axis_tdata))

endmodule

bind sat_convex_polygon_overlap_core scpo_checker u_scpo_checker (.*);
